@@ sv/mtg_pkg.sv @@
package mtg_pkg;

  localparam int KEY_WORDS = 64;
  localparam int KEY_AW    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KCW       = $clog2(KEY_WORDS + 1);
  localparam int N_WORDS   = 624;
  localparam int N_AW      = 10;
  localparam int N_SHIFT   = 397;
  localparam int CNT_MAX   = (KEY_WORDS > N_WORDS) ? KEY_WORDS : N_WORDS;
  localparam int CW        = $clog2(CNT_MAX + 1);

  localparam logic [31:0] MATRIX   = 32'h9908b0df;
  localparam logic [31:0] UPPER    = 32'h80000000;
  localparam logic [31:0] LOWER    = 32'h7fffffff;
  localparam logic [31:0] MUL_LIN  = 32'd1812433253;
  localparam logic [31:0] MUL_KEY  = 32'd1664525;
  localparam logic [31:0] MUL_MIX  = 32'd1566083941;
  localparam logic [31:0] SEED_KEY = 32'd19650218;
  localparam logic [31:0] SEED_DEF = 32'd5489;
  localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C = 32'hefc60000;

  localparam logic [N_AW-1:0] IDX_FULL  = N_AW'(N_WORDS);
  localparam logic [N_AW-1:0] IDX_NEVER = N_AW'(N_WORDS + 1);
  localparam logic [N_AW-1:0] IDX_LAST  = N_AW'(N_WORDS - 1);

  localparam logic [1:0] ST_WORD     = 2'd0;
  localparam logic [1:0] ST_SEEDED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_LIN_START, S_LIN_MUL, S_LIN_WR,
    S_KEY_RD, S_KEY_MUL, S_KEY_WR, S_KEY_WRAP,
    S_MIX_RD, S_MIX_MUL, S_MIX_WR, S_MIX_WRAP, S_KEY_FIN,
    S_REG_RA, S_REG_RB, S_REG_RF, S_REG_WR,
    S_DRAW_RD, S_DRAW_OUT, S_DONE
  } state_t;

  typedef enum logic [1:0] {G_SEEDED, G_KEY, G_DRAW} goal_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] f;
    f = {32'b0, a} * {32'b0, b};
    return f[31:0];
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ sv/mt19937_generator.sv @@
// MT19937 generator, 32-bit words.
// Input channel (in_valid/in_ready): action, seed_word, last_word.
//   action 0 stores seed_word in the key store; last_word 1 ends the key and
//   seeds the generator, returning value 0 with status 1 (status 2 when the
//   key overflowed the store, generator unchanged).
//   action 1 returns one tempered word with status 0.
// Output channel (out_valid/out_ready): value, status, held in an output
//   register until taken.
// One word is in flight at a time; in_ready is high only while the
//   sequencer is idle. Each time the 624-word state runs out, a
//   regeneration pass over every word (single read port of the state
//   memory) runs before the draw is answered.
// A one-word key runs only the linear seeding pass; a longer key adds
//   the key and mixing passes after it.
// A first draw without seeding seeds with 5489 first.
// Reset clears the control state and marks the generator unseeded; no
//   memory clearing pass is run. A stalled receiver holds the result and
//   the block takes no new word until the sequencer has handed it over.
module mt19937_generator import mtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] seed_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status
);

  result_t           res;
  logic              res_take;
  logic              st_we;
  logic [N_AW-1:0]   st_waddr, st_raddr;
  logic [31:0]       st_wdata, st_rdata;
  logic              key_we;
  logic [KEY_AW-1:0] key_waddr, key_raddr;
  logic [31:0]       key_wdata, key_rdata;

  assign res_take = res.valid && (!out_valid || out_ready);

  mtg_seq u_seq (
    .clk, .rst, .in_valid, .in_ready, .action, .seed_word, .last_word,
    .res, .res_take,
    .st_we, .st_waddr, .st_wdata, .st_raddr, .st_rdata,
    .key_we, .key_waddr, .key_wdata, .key_raddr, .key_rdata
  );

  mtg_ram #(.DEPTH(N_WORDS), .WIDTH(32), .AW(N_AW)) u_state_ram (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mtg_ram #(.DEPTH(KEY_WORDS), .WIDTH(32), .AW(KEY_AW)) u_key_ram (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      value  <= res.value;
      status <= res.status;
    end
  end

endmodule

@@ sv/mtg_ram.sv @@
module mtg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mtg_seq.sv @@
module mtg_seq import mtg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [31:0]       seed_word,
  input  logic              last_word,
  output result_t           res,
  input  logic              res_take,
  output logic              st_we,
  output logic [N_AW-1:0]   st_waddr,
  output logic [31:0]       st_wdata,
  output logic [N_AW-1:0]   st_raddr,
  input  logic [31:0]       st_rdata,
  output logic              key_we,
  output logic [KEY_AW-1:0] key_waddr,
  output logic [31:0]       key_wdata,
  output logic [KEY_AW-1:0] key_raddr,
  input  logic [31:0]       key_rdata
);

  state_t            state, state_next;
  goal_t             goal;
  logic [N_AW-1:0]   idx;
  logic [N_AW-1:0]   ki;
  logic [KEY_AW-1:0] kj;
  logic [CW-1:0]     kcnt;
  logic [KCW-1:0]    kc;
  logic [KCW-1:0]    klen;
  logic              ovf;
  logic [31:0]       p, prod, a, b;
  logic [31:0]       rvalue;
  logic [1:0]        rstatus;

  logic              take;
  logic              room;
  logic              bad;
  logic [31:0]       t_key, t_mix, t_lin, t_reg, y;
  logic [N_AW-1:0]   far;
  logic [KCW:0]      kj_inc;

  assign take   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign room   = (kc < KCW'(KEY_WORDS));
  assign bad    = ovf || !room;
  assign t_lin  = prod + {22'b0, ki};
  assign t_key  = (a ^ prod) + b + {{(32-KEY_AW){1'b0}}, kj};
  assign t_mix  = (a ^ prod) - {22'b0, ki};
  assign y      = (a & UPPER) | (b & LOWER);
  assign t_reg  = st_rdata ^ (y >> 1) ^ (y[0] ? MATRIX : 32'b0);
  assign far    = (ki < N_AW'(N_WORDS - N_SHIFT)) ? ki + N_AW'(N_SHIFT)
                                                  : ki - N_AW'(N_WORDS - N_SHIFT);
  assign kj_inc = {{(KCW+1-KEY_AW){1'b0}}, kj} + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (action) begin
            if (idx == IDX_NEVER)     state_next = S_LIN_START;
            else if (idx == IDX_FULL) state_next = S_REG_RA;
            else                      state_next = S_DRAW_RD;
          end else if (last_word) begin
            state_next = bad ? S_DONE : S_LIN_START;
          end
        end
      end
      S_LIN_START: state_next = S_LIN_MUL;
      S_LIN_MUL:   state_next = S_LIN_WR;
      S_LIN_WR: begin
        if (ki != IDX_LAST) state_next = S_LIN_MUL;
        else begin
          case (goal)
            G_KEY:   state_next = S_KEY_RD;
            G_DRAW:  state_next = S_REG_RA;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_KEY_RD:  state_next = S_KEY_MUL;
      S_KEY_MUL: state_next = S_KEY_WR;
      S_KEY_WR: begin
        if (ki == IDX_LAST)  state_next = S_KEY_WRAP;
        else if (kcnt == 1)  state_next = S_MIX_RD;
        else                 state_next = S_KEY_RD;
      end
      S_KEY_WRAP: state_next = (kcnt == 0) ? S_MIX_RD : S_KEY_RD;
      S_MIX_RD:   state_next = S_MIX_MUL;
      S_MIX_MUL:  state_next = S_MIX_WR;
      S_MIX_WR: begin
        if (ki == IDX_LAST)  state_next = S_MIX_WRAP;
        else if (kcnt == 1)  state_next = S_KEY_FIN;
        else                 state_next = S_MIX_RD;
      end
      S_MIX_WRAP: state_next = (kcnt == 0) ? S_KEY_FIN : S_MIX_RD;
      S_KEY_FIN:  state_next = S_DONE;
      S_REG_RA:   state_next = S_REG_RB;
      S_REG_RB:   state_next = S_REG_RF;
      S_REG_RF:   state_next = S_REG_WR;
      S_REG_WR:   state_next = (ki == IDX_LAST) ? S_DRAW_RD : S_REG_RA;
      S_DRAW_RD:  state_next = S_DRAW_OUT;
      S_DRAW_OUT: state_next = S_DONE;
      S_DONE:     state_next = res_take ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = ki;
    st_wdata  = t_lin;
    st_raddr  = ki;
    key_we    = take && !action && room;
    key_waddr = kc[KEY_AW-1:0];
    key_wdata = seed_word;
    key_raddr = kj;
    res.valid  = (state == S_DONE);
    res.value  = rvalue;
    res.status = rstatus;
    case (state)
      S_LIN_START: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = p;
      end
      S_LIN_WR: st_we = 1'b1;
      S_KEY_WR: begin
        st_we    = 1'b1;
        st_wdata = t_key;
      end
      S_MIX_WR: begin
        st_we    = 1'b1;
        st_wdata = t_mix;
      end
      S_KEY_WRAP, S_MIX_WRAP: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = p;
      end
      S_KEY_FIN: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = UPPER;
      end
      S_REG_RB: st_raddr = (ki == IDX_LAST) ? '0 : ki + 1'b1;
      S_REG_RF: st_raddr = far;
      S_REG_WR: begin
        st_we    = 1'b1;
        st_wdata = t_reg;
      end
      S_DRAW_RD: st_raddr = idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= IDX_NEVER;
      kc    <= '0;
      ovf   <= 1'b0;
      goal  <= G_SEEDED;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (action) begin
              goal <= G_DRAW;
              p    <= SEED_DEF;
              ki   <= (idx == IDX_NEVER) ? N_AW'(1) : '0;
              rvalue  <= '0;
              rstatus <= ST_WORD;
            end else begin
              if (room) kc <= kc + 1'b1;
              else      ovf <= 1'b1;
              if (last_word) begin
                kc      <= '0;
                ovf     <= 1'b0;
                rvalue  <= '0;
                rstatus <= bad ? ST_OVERFLOW : ST_SEEDED;
                klen    <= kc + 1'b1;
                ki      <= N_AW'(1);
                if (kc == 0) begin
                  goal <= G_SEEDED;
                  p    <= seed_word;
                end else begin
                  goal <= G_KEY;
                  p    <= SEED_KEY;
                end
              end
            end
          end
        end
        S_LIN_MUL: prod <= mul32(p ^ (p >> 30), MUL_LIN);
        S_LIN_WR: begin
          p <= t_lin;
          if (ki != IDX_LAST) ki <= ki + 1'b1;
          else begin
            idx <= IDX_FULL;
            case (goal)
              G_KEY: begin
                p    <= SEED_KEY;
                ki   <= N_AW'(1);
                kj   <= '0;
                kcnt <= (CW'(klen) > CW'(N_WORDS)) ? CW'(klen) : CW'(N_WORDS);
              end
              G_DRAW:  ki <= '0;
              default: ;
            endcase
          end
        end
        S_KEY_MUL, S_MIX_MUL: begin
          a    <= st_rdata;
          b    <= key_rdata;
          prod <= mul32(p ^ (p >> 30), (state == S_KEY_MUL) ? MUL_KEY : MUL_MIX);
        end
        S_KEY_WR, S_MIX_WR: begin
          p    <= (state == S_KEY_WR) ? t_key : t_mix;
          kcnt <= kcnt - 1'b1;
          if (state == S_KEY_WR) begin
            kj <= (kj_inc >= {1'b0, klen}) ? '0 : kj_inc[KEY_AW-1:0];
          end
          if (ki == IDX_LAST) ki <= N_AW'(1);
          else                ki <= ki + 1'b1;
          if (state == S_KEY_WR && kcnt == 1 && ki != IDX_LAST) kcnt <= CW'(N_WORDS - 1);
        end
        S_KEY_WRAP: if (kcnt == 0) kcnt <= CW'(N_WORDS - 1);
        S_KEY_FIN: idx <= IDX_FULL;
        S_REG_RB: a <= st_rdata;
        S_REG_RF: b <= st_rdata;
        S_REG_WR: begin
          if (ki == IDX_LAST) idx <= '0;
          else                ki  <= ki + 1'b1;
        end
        S_DRAW_RD: idx <= idx + 1'b1;
        S_DRAW_OUT: begin
          rvalue  <= temper(st_rdata);
          rstatus <= ST_WORD;
        end
        default: ;
      endcase
    end
  end

  a_draw_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAW_RD |-> idx < IDX_FULL) else $error("draw index out of range");
  a_waddr: assert property (@(posedge clk) disable iff (rst)
    st_we |-> st_waddr < IDX_FULL) else $error("state write out of range");
  a_kc: assert property (@(posedge clk) disable iff (rst)
    kc <= KCW'(KEY_WORDS)) else $error("key count out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !in_ready) else $error("input taken while result pending");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

import mtg_pkg::*;

class mt_scoreboard;
  logic [31:0] mt_words[N_WORDS];
  int          draw_pos;
  logic [31:0] key_words[KEY_WORDS];
  int          key_len;
  bit          key_lost;
  logic [31:0] exp_value[$];
  logic [1:0]  exp_status[$];
  int          errors;

  function new();
    draw_pos = N_WORDS + 1;
    key_len  = 0;
    key_lost = 0;
    errors   = 0;
  endfunction

  function void seed_linear(logic [31:0] s);
    mt_words[0] = s;
    for (int i = 1; i < N_WORDS; i++)
      mt_words[i] = 32'd1812433253 * (mt_words[i-1] ^ (mt_words[i-1] >> 30)) + 32'(i);
    draw_pos = N_WORDS;
  endfunction

  function void seed_array(int len);
    int i;
    int j;
    logic [31:0] p;
    i = 1;
    j = 0;
    seed_linear(32'd19650218);
    for (int k = (len > N_WORDS) ? len : N_WORDS; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + key_words[j] + 32'(j);
      i++;
      j++;
      if (i >= N_WORDS) begin
        mt_words[0] = mt_words[N_WORDS-1];
        i = 1;
      end
      if (j >= len) j = 0;
    end
    for (int k = N_WORDS - 1; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
      i++;
      if (i >= N_WORDS) begin
        mt_words[0] = mt_words[N_WORDS-1];
        i = 1;
      end
    end
    mt_words[0] = 32'h80000000;
    draw_pos = N_WORDS;
  endfunction

  function logic [31:0] twist(logic [31:0] a, logic [31:0] b, logic [31:0] far);
    logic [31:0] y;
    y = (a & 32'h80000000) | (b & 32'h7fffffff);
    return far ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'h0);
  endfunction

  function logic [31:0] next_word();
    logic [31:0] y;
    if (draw_pos >= N_WORDS) begin
      if (draw_pos != N_WORDS) seed_linear(32'd5489);
      for (int n = 0; n < N_WORDS - 1; n++)
        mt_words[n] = twist(mt_words[n], mt_words[n+1], mt_words[(n + N_SHIFT) % N_WORDS]);
      mt_words[N_WORDS-1] = twist(mt_words[N_WORDS-1], mt_words[0], mt_words[N_SHIFT-1]);
      draw_pos = 0;
    end
    y = mt_words[draw_pos];
    draw_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function void note_word(logic act, logic [31:0] w, logic last);
    if (act) begin
      exp_value.push_back(next_word());
      exp_status.push_back(ST_WORD);
      return;
    end
    if (key_len < KEY_WORDS) begin
      key_words[key_len] = w;
      key_len++;
    end else begin
      key_lost = 1;
    end
    if (!last) return;
    exp_value.push_back(32'h0);
    if (key_lost) begin
      exp_status.push_back(ST_OVERFLOW);
    end else begin
      if (key_len == 1) seed_linear(key_words[0]);
      else seed_array(key_len);
      exp_status.push_back(ST_SEEDED);
    end
    key_len  = 0;
    key_lost = 0;
  endfunction

  function void check_word(logic [31:0] v, logic [1:0] s);
    logic [31:0] ev;
    logic [1:0]  es;
    if (exp_value.size() == 0) begin
      $error("unexpected word: value %h status %0d", v, s);
      errors++;
      return;
    end
    ev = exp_value.pop_front();
    es = exp_status.pop_front();
    if (v !== ev) begin
      $error("value: expected %h, actual %h", ev, v);
      errors++;
    end
    if (s !== es) begin
      $error("status: expected %0d, actual %0d", es, s);
      errors++;
    end
  endfunction

  function int pending();
    return exp_value.size();
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [31:0] seed_word;
  logic        last_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] value;
  logic [1:0]  status;

  mt_scoreboard sb;
  bit           quiet;
  int           sent;

  mt19937_generator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .seed_word(seed_word), .last_word(last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic send_word(logic act, logic [31:0] w, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    seed_word <= w;
    last_word <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(act, w, last);
    sent++;
  endtask

  task automatic draw_word();
    send_word(1'b1, $urandom, 1'($urandom));
  endtask

  task automatic send_key(int len);
    for (int i = 0; i < len; i++) begin
      send_word(1'b0, $urandom, i == len - 1);
      if ($urandom_range(0, 15) == 0) draw_word();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    int burst;
    int seg;
    sb        = new();
    quiet     = 0;
    sent      = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = 1'b0;
    seed_word = 32'h0;
    last_word = 1'b0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // unseeded draws, one-word keys at the extremes, draw inside a key
    draw_word();
    draw_word();
    send_word(1'b0, 32'h0, 1'b1);
    draw_word();
    send_word(1'b0, 32'hffffffff, 1'b1);
    draw_word();
    send_word(1'b0, 32'h12345678, 1'b0);
    draw_word();
    send_word(1'b0, 32'hffffffff, 1'b1);
    draw_word();
    draw_word();
    drain();
    send_word(1'b0, 32'h0, 1'b0);
    send_word(1'b0, 32'h0, 1'b1);
    send_word(1'b1, 32'hffffffff, 1'b1);
    send_word(1'b1, 32'h0, 1'b0);

    seg = 0;
    while (sent < 900) begin
      quiet = ($urandom_range(0, 3) == 0);
      case (seg)
        0: len = KEY_WORDS;
        1: len = KEY_WORDS + 1;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
            6, 7: len = $urandom_range(5, 20);
            8: len = $urandom_range(KEY_WORDS - 4, KEY_WORDS);
            default: len = $urandom_range(KEY_WORDS + 1, KEY_WORDS + 6);
          endcase
        end
      endcase
      send_key(len);
      burst = (seg == 2) ? 700 : $urandom_range(0, 30);
      repeat (burst) draw_word();
      if (seg % 5 == 4) drain();
      seg++;
    end
    draw_word();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_word(value, status);
    end
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/mtg_pkg.sv
sv/mtg_ram.sv
sv/mtg_seq.sv
sv/mt19937_generator.sv
sim/tb.sv
